### sv/bfhs_pkg.sv
// ---------------------------------------------------------------------------
// bfhs_pkg
// Shared constants, request codes and controller/datapath interface types
// for the back/forward history store.
// ---------------------------------------------------------------------------
package bfhs_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int CAP_W   = 5;
    localparam int REQ_W   = 3;
    localparam int RIDX_W  = 4;
    localparam int CNT_W   = 4;
    localparam int ENTRY_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FWD   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_GOTO  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

    // Which position the single memory read port looks at
    typedef enum logic [2:0] {
        RD_IDX  = 3'd0,
        RD_SCAN = 3'd1,
        RD_BACK = 3'd2,
        RD_CUR  = 3'd3,
        RD_FWD  = 3'd4
    } rd_sel_t;

    // Which key register takes the memory read data
    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_READ = 3'd1,
        CAP_BACK = 3'd2,
        CAP_CUR  = 3'd3,
        CAP_FWD  = 3'd4
    } cap_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     take;
        logic     apply;
        logic     scan_step;
        logic     goto_set;
        logic     load_out;
        rd_sel_t  rd_sel;
        cap_sel_t cap_sel;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_goto;
        logic held_nz;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

### sv/back_forward_history_store.sv
// ---------------------------------------------------------------------------
// back_forward_history_store
// Bounded back/forward navigation history of keys with a cursor, held in a
// circular memory; every request returns the cursor neighborhood and counts.
// ---------------------------------------------------------------------------
//  Channel  | Handshake           | Payload
//  ---------+---------------------+---------------------------------------------
//  cfg      | cfg_we              | cfg_data (capacity)
//  request  | in_valid / in_stall | req_type, item_key, read_index
//  result   | out_valid/out_stall | read_*, goto_found, current_*, back_*,
//           |                     | forward_*, back_count, forward_count,
//           |                     | entry_count
//
//  A request is not taken until the previous one has been published; goto
//  adds a read and a compare per entry scanned, up to the entries held.
//  The one read port of the key memory fetches the read-at, back, current
//  and forward entries one after another.
//  Reset clears the history and sets capacity to 10; the memory is not cleared.
//  A new request is taken while a result still waits in the output register;
//  a stalled result holds, and the next one waits behind it.
// ---------------------------------------------------------------------------
module back_forward_history_store #(
    parameter int DEPTH     = bfhs_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bfhs_pkg::KEY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bfhs_pkg::CAP_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bfhs_pkg::REQ_W-1:0]    req_type,
    input  logic [KEY_WIDTH-1:0]          item_key,
    input  logic [bfhs_pkg::RIDX_W-1:0]   read_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          read_valid,
    output logic [KEY_WIDTH-1:0]          read_key,
    output logic                          goto_found,
    output logic                          current_valid,
    output logic [KEY_WIDTH-1:0]          current_key,
    output logic                          back_valid,
    output logic [KEY_WIDTH-1:0]          back_key,
    output logic                          forward_valid,
    output logic [KEY_WIDTH-1:0]          forward_key,
    output logic [bfhs_pkg::CNT_W-1:0]    back_count,
    output logic [bfhs_pkg::CNT_W-1:0]    forward_count,
    output logic [bfhs_pkg::ENTRY_W-1:0]  entry_count
);
    import bfhs_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer
    bfhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // History state and result register
    bfhs_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .item_key      (item_key),
        .read_index    (read_index),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .read_valid    (read_valid),
        .read_key      (read_key),
        .goto_found    (goto_found),
        .current_valid (current_valid),
        .current_key   (current_key),
        .back_valid    (back_valid),
        .back_key      (back_key),
        .forward_valid (forward_valid),
        .forward_key   (forward_key),
        .back_count    (back_count),
        .forward_count (forward_count),
        .entry_count   (entry_count)
    );

    // Never publish over a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded while output register busy");

    // One request at a time: a transfer closes the input until it is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while one is in flight");

    // Without a cursor there are no neighbors and no counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !current_valid) |->
            (!back_valid && !forward_valid && back_count == '0 && forward_count == '0))
        else $error("neighbor reported without a cursor");

endmodule

### sv/bfhs_ram.sv
// ---------------------------------------------------------------------------
// bfhs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bfhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/bfhs_ctrl.sv
// ---------------------------------------------------------------------------
// bfhs_ctrl
// Sequencer for the history store: takes one request, applies it, runs the
// goto scan, reads the cursor neighborhood and publishes the result.
// ---------------------------------------------------------------------------
module bfhs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bfhs_pkg::ctrl_sts_t  sts,
    output bfhs_pkg::ctrl_cmd_t  cmd
);
    import bfhs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b0_0000_0001,
        S_EXEC     = 9'b0_0000_0010,
        S_SCAN_RD  = 9'b0_0000_0100,
        S_SCAN_CMP = 9'b0_0000_1000,
        S_NB_BACK  = 9'b0_0001_0000,
        S_NB_CUR   = 9'b0_0010_0000,
        S_NB_FWD   = 9'b0_0100_0000,
        S_NB_FIN   = 9'b0_1000_0000,
        S_PUB      = 9'b1_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Ready only while waiting for a request
    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.take      = 1'b0;
        cmd.apply     = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.goto_set  = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.rd_sel    = RD_IDX;
        cmd.cap_sel   = CAP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.apply  = 1'b1;
                cmd.rd_sel = RD_IDX;
                if (sts.is_goto && sts.held_nz)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_NB_BACK;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_sel = RD_SCAN;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sts.scan_hit)
                begin
                    cmd.goto_set = 1'b1;
                    state_next   = S_NB_BACK;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_NB_BACK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_NB_BACK:
            begin
                cmd.rd_sel  = RD_BACK;
                cmd.cap_sel = CAP_READ;
                state_next  = S_NB_CUR;
            end
            S_NB_CUR:
            begin
                cmd.rd_sel  = RD_CUR;
                cmd.cap_sel = CAP_BACK;
                state_next  = S_NB_FWD;
            end
            S_NB_FWD:
            begin
                cmd.rd_sel  = RD_FWD;
                cmd.cap_sel = CAP_CUR;
                state_next  = S_NB_FIN;
            end
            S_NB_FIN:
            begin
                cmd.cap_sel = CAP_FWD;
                state_next  = S_PUB;
            end
            S_PUB:
            begin
                // Hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/bfhs_dp.sv
// ---------------------------------------------------------------------------
// bfhs_dp
// Datapath of the history store: circular key memory, oldest slot, count,
// cursor, goto scan index, neighborhood key capture and result register.
// ---------------------------------------------------------------------------
module bfhs_dp #(
    parameter int DEPTH     = bfhs_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bfhs_pkg::KEY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bfhs_pkg::CAP_W-1:0]    cfg_data,
    input  logic [bfhs_pkg::REQ_W-1:0]    req_type,
    input  logic [KEY_WIDTH-1:0]          item_key,
    input  logic [bfhs_pkg::RIDX_W-1:0]   read_index,
    input  bfhs_pkg::ctrl_cmd_t           cmd,
    output bfhs_pkg::ctrl_sts_t           sts,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          read_valid,
    output logic [KEY_WIDTH-1:0]          read_key,
    output logic                          goto_found,
    output logic                          current_valid,
    output logic [KEY_WIDTH-1:0]          current_key,
    output logic                          back_valid,
    output logic [KEY_WIDTH-1:0]          back_key,
    output logic                          forward_valid,
    output logic [KEY_WIDTH-1:0]          forward_key,
    output logic [bfhs_pkg::CNT_W-1:0]    back_count,
    output logic [bfhs_pkg::CNT_W-1:0]    forward_count,
    output logic [bfhs_pkg::ENTRY_W-1:0]  entry_count
);
    import bfhs_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int IW1  = IW + 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int WW   = (CW > RIDX_W) ? CW : RIDX_W;
    localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [IW1-1:0]  DEPTH_S   = IW1'(DEPTH);
    localparam logic [IW-1:0]   LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [CAPW-1:0] DEPTH_C   = CAPW'(DEPTH);

    // Physical slot of a position counted from the oldest entry
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [IW-1:0] pos);
        logic [IW1-1:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IW-1:0];
    endfunction

    // Control state
    logic [CAP_W-1:0]  cap_reg;
    logic [IW-1:0]     oldest_reg,  oldest_next;
    logic [CW-1:0]     held_reg,    held_next;
    logic [IW-1:0]     cursor_reg,  cursor_next;
    logic              present_reg, present_next;
    logic              found_reg,   found_next;
    logic [IW-1:0]     scan_reg,    scan_next;
    logic              out_valid_reg;

    // Latched request and captured keys
    logic [REQ_W-1:0]     req_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [RIDX_W-1:0]    ridx_reg;
    logic [KEY_WIDTH-1:0] rd_key_reg;
    logic [KEY_WIDTH-1:0] back_key_reg;
    logic [KEY_WIDTH-1:0] cur_key_reg;
    logic [KEY_WIDTH-1:0] fwd_key_reg;

    // Result register
    logic                 out_read_valid_reg;
    logic [KEY_WIDTH-1:0] out_read_key_reg;
    logic                 out_found_reg;
    logic                 out_cur_valid_reg;
    logic [KEY_WIDTH-1:0] out_cur_key_reg;
    logic                 out_back_valid_reg;
    logic [KEY_WIDTH-1:0] out_back_key_reg;
    logic                 out_fwd_valid_reg;
    logic [KEY_WIDTH-1:0] out_fwd_key_reg;
    logic [CNT_W-1:0]     out_back_cnt_reg;
    logic [CNT_W-1:0]     out_fwd_cnt_reg;
    logic [ENTRY_W-1:0]   out_entry_cnt_reg;

    // Memory port signals
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [IW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    // Add path
    logic [CAPW-1:0] cap_eff;
    logic [CW-1:0]   kept;
    logic            evict;
    logic [CW-1:0]   add_base;
    logic [IW-1:0]   oldest_inc;
    logic [IW-1:0]   add_oldest;

    // Neighborhood
    logic [CW-1:0] cursor_w;
    logic          cur_ok;
    logic          back_ok;
    logic          fwd_ok;
    logic          read_hit;
    logic          read_out_ok;
    logic [WW-1:0] ridx_w;

    // Cursor neighborhood and read-at hit
    assign cursor_w    = CW'(cursor_reg);
    assign cur_ok      = present_reg && (cursor_w < held_reg);
    assign back_ok     = cur_ok && (cursor_reg != '0);
    assign fwd_ok      = cur_ok && ((cursor_w + CW'(1)) < held_reg);
    assign ridx_w      = WW'(ridx_reg);
    assign read_hit    = ridx_w < WW'(held_reg);
    assign read_out_ok = (req_reg == REQ_READ) && read_hit;

    // Eviction decision and append slot
    always_comb
    begin
        cap_eff    = (CAPW'(cap_reg) > DEPTH_C) ? DEPTH_C : CAPW'(cap_reg);
        kept       = present_reg ? (cursor_w + CW'(1)) : held_reg;
        evict      = (CAPW'(kept) >= cap_eff) && (kept != '0) &&
                     (!present_reg || (cursor_reg != '0) || (cap_eff == CAPW'(1)));
        add_base   = evict ? (kept - CW'(1)) : kept;
        oldest_inc = (oldest_reg == LAST_SLOT) ? '0 : (oldest_reg + IW'(1));
        add_oldest = evict ? oldest_inc : oldest_reg;
    end

    assign ram_we    = cmd.apply && (req_reg == REQ_ADD) && (cap_eff != '0);
    assign ram_waddr = slot_of(add_oldest, IW'(add_base));

    // Select read position
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_IDX:  ram_raddr = slot_of(oldest_reg, read_hit ? IW'(ridx_w) : '0);
            RD_SCAN: ram_raddr = slot_of(oldest_reg, scan_reg);
            RD_BACK: ram_raddr = slot_of(oldest_reg, back_ok ? (cursor_reg - IW'(1)) : '0);
            RD_CUR:  ram_raddr = slot_of(oldest_reg, cur_ok ? cursor_reg : '0);
            RD_FWD:  ram_raddr = slot_of(oldest_reg, fwd_ok ? (cursor_reg + IW'(1)) : '0);
            default: ram_raddr = oldest_reg;
        endcase
    end

    bfhs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Apply the request to the history state
    always_comb
    begin
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        cursor_next  = cursor_reg;
        present_next = present_reg;
        found_next   = found_reg;
        scan_next    = scan_reg;
        if (cmd.take)
        begin
            found_next = 1'b0;
        end
        if (cmd.apply)
        begin
            scan_next = '0;
            unique case (req_reg)
                REQ_ADD:
                begin
                    if (cap_eff != '0)
                    begin
                        oldest_next  = add_oldest;
                        held_next    = add_base + CW'(1);
                        cursor_next  = IW'(add_base);
                        present_next = 1'b1;
                    end
                end
                REQ_BACK:
                begin
                    if (present_reg && (cursor_reg != '0))
                    begin
                        cursor_next = cursor_reg - IW'(1);
                    end
                end
                REQ_FWD:
                begin
                    if (present_reg && ((cursor_w + CW'(1)) < held_reg))
                    begin
                        cursor_next = cursor_reg + IW'(1);
                    end
                end
                REQ_CLEAR:
                begin
                    oldest_next  = '0;
                    held_next    = '0;
                    cursor_next  = '0;
                    present_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.scan_step)
        begin
            scan_next = scan_reg + IW'(1);
        end
        if (cmd.goto_set)
        begin
            cursor_next  = scan_reg;
            present_next = 1'b1;
            found_next   = 1'b1;
        end
    end

    // Status toward the controller
    assign sts.is_goto   = (req_reg == REQ_GOTO);
    assign sts.held_nz   = (held_reg != '0);
    assign sts.scan_hit  = (ram_rdata == key_reg);
    assign sts.scan_last = ((CW'(scan_reg) + CW'(1)) >= held_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            oldest_reg    <= '0;
            held_reg      <= '0;
            cursor_reg    <= '0;
            present_reg   <= 1'b0;
            found_reg     <= 1'b0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            cursor_reg  <= cursor_next;
            present_reg <= present_next;
            found_reg   <= found_next;
            scan_reg    <= scan_next;
            // Set on publish, drop once the transfer completes
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch request fields on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg  <= req_type;
            key_reg  <= item_key;
            ridx_reg <= read_index;
        end
    end

    // Capture memory read data
    always_ff @(posedge clk)
    begin
        case (cmd.cap_sel)
            CAP_READ: rd_key_reg   <= ram_rdata;
            CAP_BACK: back_key_reg <= ram_rdata;
            CAP_CUR:  cur_key_reg  <= ram_rdata;
            CAP_FWD:  fwd_key_reg  <= ram_rdata;
            default:
            begin
            end
        endcase
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_read_valid_reg <= read_out_ok;
            out_read_key_reg   <= read_out_ok ? rd_key_reg : '0;
            out_found_reg      <= found_reg;
            out_cur_valid_reg  <= cur_ok;
            out_cur_key_reg    <= cur_ok ? cur_key_reg : '0;
            out_back_valid_reg <= back_ok;
            out_back_key_reg   <= back_ok ? back_key_reg : '0;
            out_fwd_valid_reg  <= fwd_ok;
            out_fwd_key_reg    <= fwd_ok ? fwd_key_reg : '0;
            out_back_cnt_reg   <= cur_ok ? CNT_W'(cursor_reg) : '0;
            out_fwd_cnt_reg    <= cur_ok ? CNT_W'(held_reg - cursor_w - CW'(1)) : '0;
            out_entry_cnt_reg  <= ENTRY_W'(held_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_valid    = out_read_valid_reg;
    assign read_key      = out_read_key_reg;
    assign goto_found    = out_found_reg;
    assign current_valid = out_cur_valid_reg;
    assign current_key   = out_cur_key_reg;
    assign back_valid    = out_back_valid_reg;
    assign back_key      = out_back_key_reg;
    assign forward_valid = out_fwd_valid_reg;
    assign forward_key   = out_fwd_key_reg;
    assign back_count    = out_back_cnt_reg;
    assign forward_count = out_fwd_cnt_reg;
    assign entry_count   = out_entry_cnt_reg;

endmodule

### dv/history_checker.sv
// ---------------------------------------------------------------------------
// history_checker
// Watches the request, result and capacity ports of the history store. It
// keeps its own copy of the history, predicts the status of every request
// transfer, and compares each result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module history_checker #(
    parameter int DEPTH = bfhs_pkg::DEPTH_DEF,
    parameter int KW    = bfhs_pkg::KEY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bfhs_pkg::CAP_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [bfhs_pkg::REQ_W-1:0]    req_type,
    input  logic [KW-1:0]                 item_key,
    input  logic [bfhs_pkg::RIDX_W-1:0]   read_index,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          read_valid,
    input  logic [KW-1:0]                 read_key,
    input  logic                          goto_found,
    input  logic                          current_valid,
    input  logic [KW-1:0]                 current_key,
    input  logic                          back_valid,
    input  logic [KW-1:0]                 back_key,
    input  logic                          forward_valid,
    input  logic [KW-1:0]                 forward_key,
    input  logic [bfhs_pkg::CNT_W-1:0]    back_count,
    input  logic [bfhs_pkg::CNT_W-1:0]    forward_count,
    input  logic [bfhs_pkg::ENTRY_W-1:0]  entry_count,
    output int                            pending,
    output int                            fail_count
);

    import bfhs_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               read_valid;
        logic [KW-1:0]      read_key;
        logic               goto_found;
        logic               current_valid;
        logic [KW-1:0]      current_key;
        logic               back_valid;
        logic [KW-1:0]      back_key;
        logic               forward_valid;
        logic [KW-1:0]      forward_key;
        logic [CNT_W-1:0]   back_count;
        logic [CNT_W-1:0]   forward_count;
        logic [ENTRY_W-1:0] entry_count;
    } nav_status_t;

    // Shadow history: circular key store, oldest slot, fill level and cursor
    logic [KW-1:0] hist_key [DEPTH];
    int            head_slot;
    int            num_held;
    int            cur_pos;
    bit            has_cursor;
    int            cap_limit;

    nav_status_t   status_due [$];

    function automatic logic [KW-1:0] key_at(int pos);
        return hist_key[(head_slot + pos) % DEPTH];
    endfunction

    // Apply one request to the shadow history and return the status it reports
    function automatic nav_status_t step_history(logic [REQ_W-1:0] op, logic [KW-1:0] key,
                                                 logic [RIDX_W-1:0] ridx);
        nav_status_t s;
        int          eff_cap;
        s = '0;
        case (op)
            REQ_ADD:
            begin
                eff_cap = (cap_limit > DEPTH) ? DEPTH : cap_limit;
                if (eff_cap != 0)
                begin
                    // drop everything ahead of the cursor
                    if (has_cursor)
                        num_held = cur_pos + 1;
                    // evict the oldest entry when full
                    if (num_held >= eff_cap && num_held > 0 &&
                        (!has_cursor || cur_pos != 0 || eff_cap == 1))
                    begin
                        head_slot = (head_slot + 1) % DEPTH;
                        num_held--;
                    end
                    hist_key[(head_slot + num_held) % DEPTH] = key;
                    num_held++;
                    cur_pos    = num_held - 1;
                    has_cursor = 1'b1;
                end
            end
            REQ_BACK:
            begin
                if (has_cursor && cur_pos > 0)
                    cur_pos--;
            end
            REQ_FWD:
            begin
                if (has_cursor && cur_pos + 1 < num_held)
                    cur_pos++;
            end
            REQ_GOTO:
            begin
                for (int i = 0; i < num_held; i++)
                begin
                    if (!s.goto_found && key_at(i) == key)
                    begin
                        cur_pos      = i;
                        has_cursor   = 1'b1;
                        s.goto_found = 1'b1;
                    end
                end
            end
            REQ_READ:
            begin
                if (int'(ridx) < num_held)
                begin
                    s.read_valid = 1'b1;
                    s.read_key   = key_at(int'(ridx));
                end
            end
            REQ_CLEAR:
            begin
                num_held   = 0;
                head_slot  = 0;
                cur_pos    = 0;
                has_cursor = 1'b0;
            end
            default:
            begin
            end
        endcase

        // Report the neighborhood of the cursor
        if (has_cursor && cur_pos < num_held)
        begin
            s.current_valid = 1'b1;
            s.current_key   = key_at(cur_pos);
            s.back_count    = CNT_W'(cur_pos);
            s.forward_count = CNT_W'(num_held - cur_pos - 1);
            if (cur_pos > 0)
            begin
                s.back_valid = 1'b1;
                s.back_key   = key_at(cur_pos - 1);
            end
            if (cur_pos + 1 < num_held)
            begin
                s.forward_valid = 1'b1;
                s.forward_key   = key_at(cur_pos + 1);
            end
        end
        s.entry_count = ENTRY_W'(num_held);
        return s;
    endfunction

    function automatic string show(nav_status_t s);
        return $sformatf({"read %0b/%h goto %0b cur %0b/%h back %0b/%h fwd %0b/%h ",
                          "bc %0d fc %0d n %0d"},
                         s.read_valid, s.read_key, s.goto_found, s.current_valid,
                         s.current_key, s.back_valid, s.back_key, s.forward_valid,
                         s.forward_key, s.back_count, s.forward_count, s.entry_count);
    endfunction

    // Track capacity, predict on request transfers, compare on result transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        nav_status_t seen;
        nav_status_t want;
        if (!rst_n)
        begin
            head_slot  = 0;
            num_held   = 0;
            cur_pos    = 0;
            has_cursor = 1'b0;
            cap_limit  = int'(CAP_RESET);
            status_due.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{read_valid: read_valid, read_key: read_key, goto_found: goto_found,
                         current_valid: current_valid, current_key: current_key,
                         back_valid: back_valid, back_key: back_key,
                         forward_valid: forward_valid, forward_key: forward_key,
                         back_count: back_count, forward_count: forward_count,
                         entry_count: entry_count};
                if (status_due.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("ERROR: result with nothing outstanding: %s", show(seen));
                    fail_count++;
                end
                else
                begin
                    // take the oldest prediction
                    want = status_due[0];
                    status_due.delete(0);
                    if (want !== seen)
                    begin
                        if (fail_count < MAX_REPORTS)
                        begin
                            $display("ERROR: status mismatch");
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(seen));
                        end
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                cap_limit = int'(cfg_data);
            if (in_valid && !in_stall)
                status_due.push_back(step_history(req_type, item_key, read_index));
            pending <= status_due.size();
        end
    end

endmodule

### dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives the history store with a directed opening and then phases of random
// navigation at several capacities, with random gaps and result stalls; the
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;

    import bfhs_pkg::*;

    localparam int KW            = KEY_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 73;

    // Request codes the block leaves unused
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CAP_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic [KW-1:0]       item_key;
    logic [RIDX_W-1:0]   read_index;
    logic                out_valid;
    logic                out_stall;
    logic                read_valid;
    logic [KW-1:0]       read_key;
    logic                goto_found;
    logic                current_valid;
    logic [KW-1:0]       current_key;
    logic                back_valid;
    logic [KW-1:0]       back_key;
    logic                forward_valid;
    logic [KW-1:0]       forward_key;
    logic [CNT_W-1:0]    back_count;
    logic [CNT_W-1:0]    forward_count;
    logic [ENTRY_W-1:0]  entry_count;
    int                  pending;
    int                  fail_count;

    bit                  calm;
    logic [KW-1:0]       key_pool [8];

    back_forward_history_store dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .item_key      (item_key),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_valid    (read_valid),
        .read_key      (read_key),
        .goto_found    (goto_found),
        .current_valid (current_valid),
        .current_key   (current_key),
        .back_valid    (back_valid),
        .back_key      (back_key),
        .forward_valid (forward_valid),
        .forward_key   (forward_key),
        .back_count    (back_count),
        .forward_count (forward_count),
        .entry_count   (entry_count)
    );

    history_checker hist_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .item_key      (item_key),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_valid    (read_valid),
        .read_key      (read_key),
        .goto_found    (goto_found),
        .current_valid (current_valid),
        .current_key   (current_key),
        .back_valid    (back_valid),
        .back_key      (back_key),
        .forward_valid (forward_valid),
        .forward_key   (forward_key),
        .back_count    (back_count),
        .forward_count (forward_count),
        .entry_count   (entry_count),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Run limit
    initial
    begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

    // Present one request after a random gap and hold it until the transfer
    task automatic issue_request(logic [REQ_W-1:0] op, logic [KW-1:0] key,
                                 logic [RIDX_W-1:0] ridx);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= op;
        item_key   <= key;
        read_index <= ridx;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        cfg_data <= cap;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [REQ_W-1:0] pick_op();
        int roll = $urandom_range(0, 99);
        if (roll < 38)
            return REQ_ADD;
        else if (roll < 54)
            return REQ_BACK;
        else if (roll < 66)
            return REQ_FWD;
        else if (roll < 81)
            return REQ_GOTO;
        else if (roll < 95)
            return REQ_READ;
        else if (roll < 97)
            return REQ_CLEAR;
        else if (roll < 98)
            return REQ_SPARE6;
        else
            return REQ_SPARE7;
    endfunction

    // Mostly keys from the phase pool so that goto finds them
    function automatic logic [KW-1:0] pick_key();
        int roll = $urandom_range(0, 99);
        if (roll < 80)
            return key_pool[$urandom_range(0, 7)];
        else if (roll < 85)
            return '0;
        else if (roll < 90)
            return '1;
        else
            return $urandom;
    endfunction

    // Result side: stall a random number of cycles, then take one result
    initial
    begin : result_sink
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int phase_caps [NUM_PHASES];
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = REQ_ADD;
        item_key   = '0;
        read_index = '0;
        calm       = 1'b0;
        phase_caps = '{1, 16, 0, 2, 10, 16, 3, 15, 5, 16};
        phase_caps[8] = $urandom_range(0, 16);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extremes of the key, ends of navigation
        issue_request(REQ_BACK, 32'h1111_1111, 4'd0);
        issue_request(REQ_FWD, 32'h2222_2222, 4'd0);
        issue_request(REQ_GOTO, 32'h0000_0000, 4'd0);
        issue_request(REQ_READ, 32'h0, 4'd0);
        issue_request(REQ_SPARE6, 32'hFFFF_FFFF, 4'd15);
        issue_request(REQ_SPARE7, 32'h0, 4'd0);
        issue_request(REQ_ADD, 32'h0000_0000, 4'd0);
        issue_request(REQ_ADD, 32'hFFFF_FFFF, 4'd15);
        issue_request(REQ_ADD, 32'h1234_5678, 4'd0);
        issue_request(REQ_ADD, 32'hA5A5_A5A5, 4'd0);
        issue_request(REQ_FWD, 32'h0, 4'd0);
        issue_request(REQ_BACK, 32'h0, 4'd0);
        issue_request(REQ_BACK, 32'h0, 4'd0);
        issue_request(REQ_BACK, 32'h0, 4'd0);
        issue_request(REQ_BACK, 32'h0, 4'd0);
        issue_request(REQ_FWD, 32'h0, 4'd0);
        issue_request(REQ_GOTO, 32'hFFFF_FFFF, 4'd0);
        issue_request(REQ_GOTO, 32'hDEAD_BEEF, 4'd0);
        issue_request(REQ_READ, 32'h0, 4'd15);
        issue_request(REQ_READ, 32'h0, 4'd3);
        issue_request(REQ_READ, 32'h0, 4'd0);
        issue_request(REQ_ADD, 32'h5A5A_5A5A, 4'd0);
        issue_request(REQ_CLEAR, 32'h0, 4'd0);
        issue_request(REQ_BACK, 32'h0, 4'd0);
        issue_request(REQ_READ, 32'h0, 4'd0);
        settle();

        // Random phases, each on an empty store at a fresh capacity
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 8; k++)
                key_pool[k] = $urandom;
            issue_request(REQ_CLEAR, $urandom, 4'($urandom));
            settle();
            write_capacity(CAP_W'(phase_caps[p]));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // switch idling on and off now and then
                if ($urandom_range(0, 24) == 0)
                    calm = ~calm;
                issue_request(pick_op(), pick_key(), 4'($urandom_range(0, 15)));
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
sv/bfhs_pkg.sv
sv/bfhs_ram.sv
sv/bfhs_ctrl.sv
sv/bfhs_dp.sv
sv/back_forward_history_store.sv
dv/history_checker.sv
dv/testbench.sv
